// ----- hdl/esc_pkg.sv -----
// shared constants, types and helpers for the epoch seconds to calendar date block
// no dependencies; used by every other file in hdl/
package esc_pkg;

  localparam int SECS_W     = 32;
  localparam int DAYS_W     = 16;   // whole days in a 32-bit seconds count
  localparam int DCNT_W     = 17;   // day count after the offset is added
  localparam int REM_W      = 17;   // seconds within a day
  localparam int YEAR_W     = 12;
  localparam int YCNT_W     = 13;   // full-width year counter
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int CENT_W     = 6;    // year / 100 for a 12-bit year
  localparam int OFFS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REM_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0]  SECS_PER_MIN  = 17'd60;
  localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 12'd100;
  localparam logic [YEAR_W-1:0] LAST_YEAR_OF_CENTURY = 12'd99;
  localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]        DAYS_PER_LEAP_YEAR = 9'd366;

  // division by constants: drop the power-of-two factor of the divisor, then
  // multiply by ceil(2^QSHIFT / odd factor); exact over each dividend range
  localparam int DAY_PRE_SHIFT  = 7;    // 86400 = 128 * 675
  localparam int DAY_IN_W       = 25;
  localparam int DAY_RECIP_W    = 26;
  localparam int DAY_PROD_W     = 51;
  localparam int DAY_QSHIFT     = 35;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;

  localparam int HOUR_PRE_SHIFT = 4;    // 3600 = 16 * 225
  localparam int HOUR_IN_W      = 13;
  localparam int HOUR_RECIP_W   = 14;
  localparam int HOUR_PROD_W    = 27;
  localparam int HOUR_QSHIFT    = 21;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = 14'd9321;

  localparam int MIN_PRE_SHIFT  = 2;    // 60 = 4 * 15
  localparam int MIN_IN_W       = 10;
  localparam int MIN_RECIP_W    = 11;
  localparam int MIN_PROD_W     = 21;
  localparam int MIN_QSHIFT     = 14;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 11'd1093;

  localparam int CENT_PRE_SHIFT = 2;    // 100 = 4 * 25
  localparam int CENT_IN_W      = 10;
  localparam int CENT_RECIP_W   = 11;
  localparam int CENT_PROD_W    = 21;
  localparam int CENT_QSHIFT    = 15;
  localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 11'd1311;

  localparam logic [YEAR_W-1:0] START_YEAR_RST = 12'd1970;
  localparam logic [OFFS_W-1:0] DAY_OFFSET_RST = 3'd0;

  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_OFFSET = 2'd1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

  // seconds split into days and time of day
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } split_t;

  // days in a month, month counted from 1
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (month == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = MONTH_LEN[month - MONTH_JAN];
    end else begin
      len = MONTH_LEN[0];
    end
    return len;
  endfunction

endpackage

// ----- hdl/esc_if.sv -----
// valid/ready channel interfaces for the input seconds and the calendar result
// depends on esc_pkg
interface esc_in_if;
  logic                        valid;
  logic                        ready;
  logic [esc_pkg::SECS_W-1:0]  elapsed_secs;

  modport source (output valid, output elapsed_secs, input ready);
  modport sink   (input valid, input elapsed_secs, output ready);
endinterface

interface esc_out_if;
  logic                         valid;
  logic                         ready;
  logic [esc_pkg::YEAR_W-1:0]   year;
  logic [esc_pkg::MONTH_W-1:0]  month;
  logic [esc_pkg::DAY_W-1:0]    day_of_month;
  logic [esc_pkg::HOUR_W-1:0]   hour;
  logic [esc_pkg::MIN_W-1:0]    minute;
  logic [esc_pkg::SEC_W-1:0]    second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

// ----- hdl/epoch_seconds_to_calendar_date.sv -----
// Converts an unsigned 32-bit count of seconds since January 1, 00:00:00 of a
// programmable start year into Gregorian year, month, day of month, hour, minute
// and second, one result per input transaction. A programmable 0..7 whole-day
// offset is added to the day count (5 for the ATSC epoch, 0 for Unix). The front
// end splits the count by reciprocal multiplication, one multiply or subtract
// per cycle: an accept state, the working states F_DAY, F_REM, F_HOUR, F_MIN,
// F_SEC and F_TRIM, and a push state that waits for the queue; the result goes
// to a two-entry queue. The back end derives the century (B_INIT), then the year
// within the century (B_MOD) of the start year, then walks one year per cycle
// and one month per cycle, over at most 136 years since that is all a 32-bit
// count spans. The year walk sets the throughput; the front end runs ahead on
// the next transaction meanwhile. The result sits in an output register, so a
// stalled sink does not stop the walk already in progress.
// Registers: index 0 is the start year (12 bits, reset 1970), index 1 is
// day_offset (3 bits, reset 0); writes to other indexes are dropped, and
// registers should only be written while no transaction is in flight.
module epoch_seconds_to_calendar_date (
  input  logic                             clk,
  input  logic                             rst_n,
  esc_in_if.sink                           in_if,
  esc_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [esc_pkg::YEAR_W-1:0]   start_year_r;
  logic [esc_pkg::OFFS_W-1:0]   day_offset_r;

  // front end to queue
  logic                         push_valid;
  logic                         push_ready;
  esc_pkg::split_t              push_data;

  // queue to back end
  logic                         pop_valid;
  logic                         pop_ready;
  esc_pkg::split_t              pop_data;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r <= esc_pkg::START_YEAR_RST;
      day_offset_r <= esc_pkg::DAY_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        esc_pkg::REG_START_YEAR: begin
          start_year_r <= cfg_data[esc_pkg::YEAR_W-1:0];
        end
        esc_pkg::REG_DAY_OFFSET: begin
          day_offset_r <= cfg_data[esc_pkg::OFFS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // seconds split into days and time of day
  esc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples the divider from the calendar walk
  esc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // year and month walk plus output register
  esc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_year (start_year_r),
    .day_offset (day_offset_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_if     (out_if)
  );

endmodule

// ----- hdl/esc_front.sv -----
// front end: accepts a seconds count and splits it into days, hour, minute, second
// depends on esc_pkg and esc_if
module esc_front (
  input  logic            clk,
  input  logic            rst_n,
  esc_in_if.sink          in_if,
  output logic            push_valid,
  input  logic            push_ready,
  output esc_pkg::split_t push_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DAY  = 3'd1;
  localparam logic [2:0] F_REM  = 3'd2;
  localparam logic [2:0] F_HOUR = 3'd3;
  localparam logic [2:0] F_MIN  = 3'd4;
  localparam logic [2:0] F_SEC  = 3'd5;
  localparam logic [2:0] F_TRIM = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [esc_pkg::SECS_W-1:0]      secs_r, secs_nxt;
  logic [esc_pkg::DAYS_W-1:0]      days_r, days_nxt;
  logic [esc_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [esc_pkg::HOUR_W-1:0]      hour_r, hour_nxt;
  logic [esc_pkg::MIN_W-1:0]       minute_r, minute_nxt;

  logic [esc_pkg::DAY_PROD_W-1:0]  day_prod;
  logic [esc_pkg::HOUR_PROD_W-1:0] hour_prod;
  logic [esc_pkg::MIN_PROD_W-1:0]  min_prod;
  logic [esc_pkg::REM_W-1:0]       day_secs;
  logic [esc_pkg::REM_W-1:0]       hour_secs;
  logic [esc_pkg::REM_W-1:0]       min_secs;

  // quotients by reciprocal multiplication, one step per cycle
  assign day_prod  = esc_pkg::DAY_PROD_W'(secs_r[esc_pkg::DAY_PRE_SHIFT +: esc_pkg::DAY_IN_W])
                   * esc_pkg::DAY_PROD_W'(esc_pkg::DAY_RECIP);
  assign hour_prod = esc_pkg::HOUR_PROD_W'(rem_r[esc_pkg::HOUR_PRE_SHIFT +: esc_pkg::HOUR_IN_W])
                   * esc_pkg::HOUR_PROD_W'(esc_pkg::HOUR_RECIP);
  assign min_prod  = esc_pkg::MIN_PROD_W'(rem_r[esc_pkg::MIN_PRE_SHIFT +: esc_pkg::MIN_IN_W])
                   * esc_pkg::MIN_PROD_W'(esc_pkg::MIN_RECIP);

  // low bits of quotient times divisor, enough since each remainder fits
  assign day_secs  = esc_pkg::REM_W'(days_r) * esc_pkg::SECS_PER_DAY;
  assign hour_secs = esc_pkg::REM_W'(hour_r) * esc_pkg::SECS_PER_HOUR;
  assign min_secs  = esc_pkg::REM_W'(minute_r) * esc_pkg::SECS_PER_MIN;

  assign in_if.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);

  assign push_data.days   = days_r;
  assign push_data.hour   = hour_r;
  assign push_data.minute = minute_r;
  assign push_data.second = rem_r[esc_pkg::SEC_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    secs_nxt   = secs_r;
    days_nxt   = days_r;
    rem_nxt    = rem_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_if.valid) begin
          secs_nxt  = in_if.elapsed_secs;
          state_nxt = F_DAY;
        end
      end
      F_DAY: begin
        days_nxt  = day_prod[esc_pkg::DAY_QSHIFT +: esc_pkg::DAYS_W];
        state_nxt = F_REM;
      end
      F_REM: begin
        rem_nxt   = secs_r[esc_pkg::REM_W-1:0] - day_secs;
        state_nxt = F_HOUR;
      end
      F_HOUR: begin
        hour_nxt  = hour_prod[esc_pkg::HOUR_QSHIFT +: esc_pkg::HOUR_W];
        state_nxt = F_MIN;
      end
      F_MIN: begin
        rem_nxt   = rem_r - hour_secs;
        state_nxt = F_SEC;
      end
      F_SEC: begin
        minute_nxt = min_prod[esc_pkg::MIN_QSHIFT +: esc_pkg::MIN_W];
        state_nxt  = F_TRIM;
      end
      F_TRIM: begin
        rem_nxt   = rem_r - min_secs;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    secs_r   <= secs_nxt;
    days_r   <= days_nxt;
    rem_r    <= rem_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
  end

endmodule

// ----- hdl/esc_queue.sv -----
// two-entry queue between the front end and the calendar walk
// depends on esc_pkg
module esc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  esc_pkg::split_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output esc_pkg::split_t pop_data
);

  localparam int PTR_W = $clog2(esc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(esc_pkg::QUEUE_DEPTH + 1);

  esc_pkg::split_t    mem_r [esc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(esc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= PTR_W'((int'(wr_ptr_r) + 1) % esc_pkg::QUEUE_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_r <= PTR_W'((int'(rd_ptr_r) + 1) % esc_pkg::QUEUE_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/esc_back.sv -----
// back end: walks years and months from the start year and drives the result register
// depends on esc_pkg and esc_if
module esc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [esc_pkg::YEAR_W-1:0]   start_year,
  input  logic [esc_pkg::OFFS_W-1:0]   day_offset,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  esc_pkg::split_t              pop_data,
  esc_out_if.source                    out_if
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_INIT  = 3'd1;
  localparam logic [2:0] B_MOD   = 3'd2;
  localparam logic [2:0] B_YEAR  = 3'd3;
  localparam logic [2:0] B_MONTH = 3'd4;
  localparam logic [2:0] B_DONE  = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [esc_pkg::DCNT_W-1:0]    days_r, days_nxt;
  logic [esc_pkg::YCNT_W-1:0]    year_r, year_nxt;
  logic [esc_pkg::YEAR_W-1:0]    c100_r, c100_nxt;   // year mod 100 after init
  logic [esc_pkg::CENT_W-1:0]    cent_r, cent_nxt;   // century count, low bits matter
  logic [esc_pkg::MONTH_W-1:0]   month_r, month_nxt;
  esc_pkg::split_t               hold_r, hold_nxt;

  logic                          out_valid_r;
  logic [esc_pkg::YEAR_W-1:0]    year_o_r;
  logic [esc_pkg::MONTH_W-1:0]   month_o_r;
  logic [esc_pkg::DAY_W-1:0]     mday_o_r;
  logic [esc_pkg::HOUR_W-1:0]    hour_o_r;
  logic [esc_pkg::MIN_W-1:0]     minute_o_r;
  logic [esc_pkg::SEC_W-1:0]     second_o_r;

  logic [esc_pkg::CENT_PROD_W-1:0] cent_prod;
  logic [esc_pkg::YEAR_W-1:0]    cent_years;
  logic                          leap;
  logic [8:0]                    ylen;
  logic [esc_pkg::DAY_W-1:0]     mlen;
  logic                          out_free;
  logic                          out_load;

  // start year / 100 by reciprocal multiplication, then the year within the century
  assign cent_prod  = esc_pkg::CENT_PROD_W'(c100_r[esc_pkg::CENT_PRE_SHIFT +:
                                                   esc_pkg::CENT_IN_W])
                    * esc_pkg::CENT_PROD_W'(esc_pkg::CENT_RECIP);
  assign cent_years = esc_pkg::YEAR_W'(cent_r) * esc_pkg::YEARS_PER_CENTURY;

  // 4/100/400 rule from the running mod-100 and century counters
  assign leap = (c100_r != '0) ? (year_r[1:0] == 2'd0) : (cent_r[1:0] == 2'd0);
  assign ylen = leap ? esc_pkg::DAYS_PER_LEAP_YEAR : esc_pkg::DAYS_PER_YEAR;
  assign mlen = esc_pkg::month_len(month_r, leap);

  assign out_free  = !out_valid_r || out_if.ready;
  assign out_load  = (state_r == B_DONE) && out_free;
  assign pop_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    days_nxt  = days_r;
    year_nxt  = year_r;
    c100_nxt  = c100_r;
    cent_nxt  = cent_r;
    month_nxt = month_r;
    hold_nxt  = hold_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          days_nxt  = esc_pkg::DCNT_W'(pop_data.days) + esc_pkg::DCNT_W'(day_offset);
          year_nxt  = esc_pkg::YCNT_W'(start_year);
          c100_nxt  = start_year;
          hold_nxt  = pop_data;
          state_nxt = B_INIT;
        end
      end
      B_INIT: begin
        cent_nxt  = cent_prod[esc_pkg::CENT_QSHIFT +: esc_pkg::CENT_W];
        state_nxt = B_MOD;
      end
      B_MOD: begin
        c100_nxt  = c100_r - cent_years;
        state_nxt = B_YEAR;
      end
      B_YEAR: begin
        if (days_r < esc_pkg::DCNT_W'(ylen)) begin
          month_nxt = esc_pkg::MONTH_JAN;
          state_nxt = B_MONTH;
        end else begin
          days_nxt = days_r - esc_pkg::DCNT_W'(ylen);
          year_nxt = year_r + esc_pkg::YCNT_W'(1);
          if (c100_r == esc_pkg::LAST_YEAR_OF_CENTURY) begin
            c100_nxt = '0;
            cent_nxt = cent_r + esc_pkg::CENT_W'(1);
          end else begin
            c100_nxt = c100_r + esc_pkg::YEAR_W'(1);
          end
        end
      end
      B_MONTH: begin
        if (days_r < esc_pkg::DCNT_W'(mlen) || month_r == esc_pkg::MONTH_DEC) begin
          state_nxt = B_DONE;
        end else begin
          days_nxt  = days_r - esc_pkg::DCNT_W'(mlen);
          month_nxt = month_r + esc_pkg::MONTH_W'(1);
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    days_r  <= days_nxt;
    year_r  <= year_nxt;
    c100_r  <= c100_nxt;
    cent_r  <= cent_nxt;
    month_r <= month_nxt;
    hold_r  <= hold_nxt;
    if (out_load) begin
      year_o_r   <= year_r[esc_pkg::YEAR_W-1:0];
      month_o_r  <= month_r;
      mday_o_r   <= esc_pkg::DAY_W'(days_r + esc_pkg::DCNT_W'(1));
      hour_o_r   <= hold_r.hour;
      minute_o_r <= hold_r.minute;
      second_o_r <= hold_r.second;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.year         = year_o_r;
  assign out_if.month        = month_o_r;
  assign out_if.day_of_month = mday_o_r;
  assign out_if.hour         = hour_o_r;
  assign out_if.minute       = minute_o_r;
  assign out_if.second       = second_o_r;

endmodule
